// ----- hw/rtl/ptrsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrsp_pkg
// Shared types and constants of the path teach and replay speed planner.
// ----------------------------------------------------------------------------
package ptrsp_pkg;

    localparam int MAX_POINTS_DEF  = 512;
    localparam int MIN_RECORD_DIST = 100;

    // configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    typedef enum logic [2:0] {
        REG_GYRO_ENTER   = 3'd0,
        REG_GYRO_EXIT    = 3'd1,
        REG_TURN_ANGLE   = 3'd2,
        REG_RIGHT_ANGLE  = 3'd3,
        REG_LONG_STRAIGHT = 3'd4,
        REG_SPEED_FAST   = 3'd5,
        REG_SPEED_MEDIUM = 3'd6,
        REG_SPEED_CORNER = 3'd7
    } t_reg_idx;

    localparam logic [14:0] GYRO_ENTER_RST    = 15'd1640;
    localparam logic [14:0] GYRO_EXIT_RST     = 15'd328;
    localparam logic [14:0] TURN_ANGLE_RST    = 15'd450;
    localparam logic [14:0] RIGHT_ANGLE_RST   = 15'd900;
    localparam logic [23:0] LONG_STRAIGHT_RST = 24'd5000;
    localparam logic [9:0]  SPEED_FAST_RST    = 10'd320;
    localparam logic [9:0]  SPEED_MEDIUM_RST  = 10'd230;
    localparam logic [9:0]  SPEED_CORNER_RST  = 10'd160;

    typedef struct packed {
        logic [14:0] gyro_enter_level;
        logic [14:0] gyro_exit_level;
        logic [14:0] turn_angle_min;
        logic [14:0] right_angle;
        logic [23:0] long_straight;
        logic [9:0]  speed_fast;
        logic [9:0]  speed_medium;
        logic [9:0]  speed_corner;
    } t_cfg;

endpackage

// ----- hw/rtl/ptrsp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrsp_cfg
// APB-style register file holding the planner thresholds and speeds.
// ----------------------------------------------------------------------------
module ptrsp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptrsp_pkg::CFG_AW-1:0]  paddr,
    input  logic [ptrsp_pkg::CFG_DW-1:0]  pwdata,
    output logic [ptrsp_pkg::CFG_DW-1:0]  prdata,
    output logic                          pready,
    output ptrsp_pkg::t_cfg               o_cfg
);

    ptrsp_pkg::t_cfg      r_cfg;
    ptrsp_pkg::t_reg_idx  reg_idx;
    logic                 wr_en;

    assign reg_idx = ptrsp_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gyro_enter_level <= ptrsp_pkg::GYRO_ENTER_RST;
            r_cfg.gyro_exit_level  <= ptrsp_pkg::GYRO_EXIT_RST;
            r_cfg.turn_angle_min   <= ptrsp_pkg::TURN_ANGLE_RST;
            r_cfg.right_angle      <= ptrsp_pkg::RIGHT_ANGLE_RST;
            r_cfg.long_straight    <= ptrsp_pkg::LONG_STRAIGHT_RST;
            r_cfg.speed_fast       <= ptrsp_pkg::SPEED_FAST_RST;
            r_cfg.speed_medium     <= ptrsp_pkg::SPEED_MEDIUM_RST;
            r_cfg.speed_corner     <= ptrsp_pkg::SPEED_CORNER_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                ptrsp_pkg::REG_GYRO_ENTER:    r_cfg.gyro_enter_level <= pwdata[14:0];
                ptrsp_pkg::REG_GYRO_EXIT:     r_cfg.gyro_exit_level  <= pwdata[14:0];
                ptrsp_pkg::REG_TURN_ANGLE:    r_cfg.turn_angle_min   <= pwdata[14:0];
                ptrsp_pkg::REG_RIGHT_ANGLE:   r_cfg.right_angle      <= pwdata[14:0];
                ptrsp_pkg::REG_LONG_STRAIGHT: r_cfg.long_straight    <= pwdata[23:0];
                ptrsp_pkg::REG_SPEED_FAST:    r_cfg.speed_fast       <= pwdata[9:0];
                ptrsp_pkg::REG_SPEED_MEDIUM:  r_cfg.speed_medium     <= pwdata[9:0];
                ptrsp_pkg::REG_SPEED_CORNER:  r_cfg.speed_corner     <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            ptrsp_pkg::REG_GYRO_ENTER:    prdata = 32'(r_cfg.gyro_enter_level);
            ptrsp_pkg::REG_GYRO_EXIT:     prdata = 32'(r_cfg.gyro_exit_level);
            ptrsp_pkg::REG_TURN_ANGLE:    prdata = 32'(r_cfg.turn_angle_min);
            ptrsp_pkg::REG_RIGHT_ANGLE:   prdata = 32'(r_cfg.right_angle);
            ptrsp_pkg::REG_LONG_STRAIGHT: prdata = 32'(r_cfg.long_straight);
            ptrsp_pkg::REG_SPEED_FAST:    prdata = 32'(r_cfg.speed_fast);
            ptrsp_pkg::REG_SPEED_MEDIUM:  prdata = 32'(r_cfg.speed_medium);
            ptrsp_pkg::REG_SPEED_CORNER:  prdata = 32'(r_cfg.speed_corner);
            default:                      prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/path_teach_replay_speed_planner_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_teach_replay_speed_planner_top
// Records turn points of a taught path and replays them as a speed profile.
// ----------------------------------------------------------------------------
// One request is handled at a time. A record request passes through accept,
// table write and result load. A replay request that only checks the table
// end passes through accept, a fetch of the current point and result load; one
// that walks the table reads the point table, a synchronous memory with a
// single read port, so the current, previous and next points are read one
// after another. The next request is accepted in the cycle after the result is
// loaded, even while that result still waits to be taken; a stalled output
// holds the block in its last step. Entry zero of the table is never written
// and always reads as zero, so no clearing pass follows reset.
module path_teach_replay_speed_planner_top #(
    parameter int MAX_POINTS = ptrsp_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptrsp_pkg::CFG_AW-1:0]  paddr,
    input  logic [ptrsp_pkg::CFG_DW-1:0]  pwdata,
    output logic [ptrsp_pkg::CFG_DW-1:0]  prdata,
    output logic                          pready,
    // tick requests
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic signed [15:0]            i_gyro_rate,
    input  logic signed [15:0]            i_heading,
    input  logic [23:0]                   i_travelled,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [9:0]                    o_speed,
    output logic                          o_point_recorded,
    output logic                          o_restart_odometry,
    output logic                          o_finished,
    output logic [8:0]                    o_segment_index
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int EW = 41;

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_RECORD     = 6'b000010,
        ST_FETCH_CUR  = 6'b000100,
        ST_FETCH_A    = 6'b001000,
        ST_FETCH_NEXT = 6'b010000,
        ST_DONE       = 6'b100000
    } t_state;

    function automatic logic [15:0] f_mag(input logic [15:0] v);
        return v[15] ? (~v + 16'd1) : v;
    endfunction

    ptrsp_pkg::t_cfg cfg;

    ptrsp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // point table: {dist[23:0], heading[15:0], turn}
    logic [EW-1:0] r_mem [MAX_POINTS];
    logic [EW-1:0] r_rd_data;
    logic          r_rd_zero;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_zero <= (rd_addr == '0);
        end
    end

    // entry zero reads as the cleared point
    logic [23:0] rd_dist;
    logic [15:0] rd_ang;
    logic        rd_turn;
    assign rd_dist = r_rd_zero ? 24'd0 : r_rd_data[40:17];
    assign rd_ang  = r_rd_zero ? 16'd0 : r_rd_data[16:1];
    assign rd_turn = r_rd_zero ? 1'b0  : r_rd_data[0];

    // control and state
    t_state        r_state, n_state;
    logic [AW-1:0] r_pc, n_pc;
    logic          r_in_turn, n_in_turn;
    logic [AW-1:0] r_ri, n_ri;
    logic          r_end_seen, n_end_seen;
    logic [9:0]    r_held, n_held;
    logic          r_out_valid, n_out_valid;

    // per-request working registers
    logic          r_mode, n_mode;
    logic [15:0]   r_gmag, n_gmag;
    logic [15:0]   r_head, n_head;
    logic [23:0]   r_trav, n_trav;
    logic          r_adv, n_adv;
    logic [23:0]   r_prev_dist, n_prev_dist;
    logic [23:0]   r_cur_dist, n_cur_dist;
    logic [15:0]   r_cur_ang, n_cur_ang;
    logic          r_cur_turn, n_cur_turn;
    logic          r_res_rec, n_res_rec;
    logic          r_res_restart, n_res_restart;
    logic          r_res_fin, n_res_fin;

    // output payload
    logic [9:0]    r_o_speed, n_o_speed;
    logic          r_o_rec, n_o_rec;
    logic          r_o_restart, n_o_restart;
    logic          r_o_fin, n_o_fin;
    logic [8:0]    r_o_idx, n_o_idx;

    logic          in_acc;
    logic [AW:0]   pc_p1;
    logic [AW:0]   ri_p1;
    logic          room, far, hit;
    logic          walk, reached;
    logic [24:0]   seg_len;
    logic [24:0]   twice_trav;
    logic [24:0]   mid_sum;
    logic          is_long;
    logic [9:0]    appr_speed;
    logic [31:0]   idx_wide;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;

    assign pc_p1   = {1'b0, r_pc} + {{AW{1'b0}}, 1'b1};
    assign ri_p1   = {1'b0, r_ri} + {{AW{1'b0}}, 1'b1};
    assign room    = pc_p1 < (AW+1)'(MAX_POINTS);
    assign far     = r_trav > 24'(ptrsp_pkg::MIN_RECORD_DIST);
    assign hit     = r_in_turn ? (r_gmag < {1'b0, cfg.gyro_exit_level})
                               : ((r_gmag > {1'b0, cfg.gyro_enter_level}) &&
                                  (f_mag(r_head) >= {1'b0, cfg.turn_angle_min}));
    assign walk    = ri_p1 < {1'b0, r_pc};
    assign reached = r_trav >= rd_dist;

    // speed choice, evaluated while the next point is on the read port
    assign seg_len    = {1'b0, r_cur_dist} - {1'b0, r_prev_dist};
    assign is_long    = !seg_len[24] && (seg_len[23:0] > cfg.long_straight);
    assign twice_trav = {r_trav, 1'b0};
    assign mid_sum    = {1'b0, r_prev_dist} + {1'b0, r_cur_dist};
    assign appr_speed = (f_mag(rd_ang) >= {1'b0, cfg.right_angle}) ? cfg.speed_corner
                                                                   : cfg.speed_medium;

    assign idx_wide = r_mode ? 32'(r_ri) : 32'(r_pc);

    always_comb begin
        n_state       = r_state;
        n_pc          = r_pc;
        n_in_turn     = r_in_turn;
        n_ri          = r_ri;
        n_end_seen    = r_end_seen;
        n_held        = r_held;
        n_out_valid   = r_out_valid & ~i_out_ready;
        n_mode        = r_mode;
        n_gmag        = r_gmag;
        n_head        = r_head;
        n_trav        = r_trav;
        n_adv         = r_adv;
        n_prev_dist   = r_prev_dist;
        n_cur_dist    = r_cur_dist;
        n_cur_ang     = r_cur_ang;
        n_cur_turn    = r_cur_turn;
        n_res_rec     = r_res_rec;
        n_res_restart = r_res_restart;
        n_res_fin     = r_res_fin;
        n_o_speed     = r_o_speed;
        n_o_rec       = r_o_rec;
        n_o_restart   = r_o_restart;
        n_o_fin       = r_o_fin;
        n_o_idx       = r_o_idx;
        rd_en         = 1'b0;
        rd_addr       = r_ri;
        wr_en         = 1'b0;
        wr_addr       = pc_p1[AW-1:0];
        wr_data       = {r_trav, r_head, r_in_turn};

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_mode        = i_mode;
                    n_gmag        = f_mag(i_gyro_rate);
                    n_head        = i_heading;
                    n_trav        = i_travelled;
                    n_res_rec     = 1'b0;
                    n_res_restart = 1'b0;
                    n_res_fin     = 1'b0;
                    // replay starts by fetching the current point
                    rd_en         = i_mode;
                    rd_addr       = r_ri;
                    n_state       = i_mode ? ST_FETCH_CUR : ST_RECORD;
                end
            end
            ST_RECORD: begin
                if (room && far && hit) begin
                    wr_en     = 1'b1;
                    n_pc      = pc_p1[AW-1:0];
                    n_in_turn = ~r_in_turn;
                    n_res_rec = 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_FETCH_CUR: begin
                if (walk) begin
                    n_adv = reached;
                    rd_en = 1'b1;
                    if (reached) begin
                        // old current point becomes the previous one
                        n_prev_dist = rd_dist;
                        n_ri        = ri_p1[AW-1:0];
                        rd_addr     = ri_p1[AW-1:0];
                    end else begin
                        n_cur_dist = rd_dist;
                        n_cur_ang  = rd_ang;
                        n_cur_turn = rd_turn;
                        rd_addr    = r_ri - {{(AW-1){1'b0}}, 1'b1};
                    end
                    n_state = ST_FETCH_A;
                end else begin
                    if (!r_end_seen) begin
                        if (reached) begin
                            n_ri          = {{(AW-1){1'b0}}, 1'b1};
                            n_end_seen    = 1'b1;
                            n_res_restart = 1'b1;
                        end
                    end else begin
                        n_res_fin = 1'b1;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_FETCH_A: begin
                if (r_adv) begin
                    n_cur_dist = rd_dist;
                    n_cur_ang  = rd_ang;
                    n_cur_turn = rd_turn;
                end else begin
                    n_prev_dist = rd_dist;
                end
                rd_en   = 1'b1;
                rd_addr = ri_p1[AW-1:0];
                n_state = ST_FETCH_NEXT;
            end
            ST_FETCH_NEXT: begin
                if (r_cur_turn) begin
                    n_held = (f_mag(r_cur_ang) >= {1'b0, cfg.right_angle}) ? cfg.speed_corner
                                                                           : cfg.speed_medium;
                end else if (is_long && (twice_trav < mid_sum)) begin
                    n_held = cfg.speed_fast;
                end else begin
                    n_held = appr_speed;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_speed   = r_held;
                    n_o_rec     = r_res_rec;
                    n_o_restart = r_res_restart;
                    n_o_fin     = r_res_fin;
                    n_o_idx     = idx_wide[8:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_in_turn   <= 1'b0;
            r_ri        <= {{(AW-1){1'b0}}, 1'b1};
            r_end_seen  <= 1'b0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_in_turn   <= n_in_turn;
            r_ri        <= n_ri;
            r_end_seen  <= n_end_seen;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode        <= n_mode;
        r_gmag        <= n_gmag;
        r_head        <= n_head;
        r_trav        <= n_trav;
        r_adv         <= n_adv;
        r_prev_dist   <= n_prev_dist;
        r_cur_dist    <= n_cur_dist;
        r_cur_ang     <= n_cur_ang;
        r_cur_turn    <= n_cur_turn;
        r_res_rec     <= n_res_rec;
        r_res_restart <= n_res_restart;
        r_res_fin     <= n_res_fin;
        r_o_speed     <= n_o_speed;
        r_o_rec       <= n_o_rec;
        r_o_restart   <= n_o_restart;
        r_o_fin       <= n_o_fin;
        r_o_idx       <= n_o_idx;
    end

    assign o_out_valid        = r_out_valid;
    assign o_speed            = r_o_speed;
    assign o_point_recorded   = r_o_rec;
    assign o_restart_odometry = r_o_restart;
    assign o_finished         = r_o_fin;
    assign o_segment_index    = r_o_idx;

endmodule
